/* sv/imm_pkg.sv */
// Shared constants and types for the integer matrix multiplier.
`default_nettype none

package imm_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_DIM_DEFAULT    = 8;
    localparam int ELEM_WIDTH_DEFAULT = 32;

    // Fixed field widths of the stream words.
    localparam int DIM_W    = 4;
    localparam int IDX_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int DATA_W   = 40;
    localparam int DIM_RESET = 8;

    // Result queue depth; it also bounds the entries in flight.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

/* sv/integer_matrix_multiply.sv */
// Integer matrix multiplier: two element memories, one multiply-accumulate pipeline.
//
// A word with operation write-A or write-B stores one element of A or B at its
// row and column; writes outside the dimensions in use are dropped. A compute
// word emits C = A * B in row-major order, one word per entry, tlast on the
// final one. The compute walks one product per cycle, while a queue slot can
// be reserved, through a single 32x32 multiply-accumulate unit fed from the A
// and B memories; each product passes the registered memory read and the
// registered product before it is summed. No input word is taken while
// products are still being issued. A four-word result queue decouples the
// output; when it and the entries in flight fill it, the issue of the next
// entry waits. Elements that were never written read as unknown values.
`default_nettype none

module integer_matrix_multiply
    import imm_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEFAULT,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // Input stream. tdata: row_index[2:0], col_index[5:3], element_value[37:6], zeros.
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [DATA_W-1:0]     s_axis_tdata,
    // tuser: operation[1:0].
    input  wire  [OP_W-1:0]       s_axis_tuser,
    // Result stream. tdata: out_row[2:0], out_col[5:3], product_value[37:6], zeros.
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,
    output logic                  m_axis_tlast,
    // Configuration writes.
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire  [DIM_W-1:0]      i_cfg_wdata
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [DIM_W-1:0] RST_DIM =
        DIM_W'((MAX_DIM < DIM_RESET) ? MAX_DIM : DIM_RESET);

    function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    // ---------------- configuration ----------------
    logic [DIM_W-1:0] r_rows_a, r_inner, r_cols_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= RST_DIM;
            r_inner  <= RST_DIM;
            r_cols_b <= RST_DIM;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_ROWS_A:    r_rows_a <= limit_dim(i_cfg_wdata);
                CFG_INNER_DIM: r_inner  <= limit_dim(i_cfg_wdata);
                CFG_COLS_B:    r_cols_b <= limit_dim(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // ---------------- input decode ----------------
    logic                   in_fire;
    t_op                    in_op;
    logic [IDX_W-1:0]       in_row, in_col;
    logic [VALUE_W-1:0]     in_value;
    logic signed [63:0]     in_sx;
    logic [ELEM_WIDTH-1:0]  wr_data;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   wr_a_en, wr_b_en;
    logic                   r_busy;

    assign s_axis_tready = !r_busy;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_op    = t_op'(s_axis_tuser);
    assign in_row   = s_axis_tdata[IDX_W-1:0];
    assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_value = s_axis_tdata[2*IDX_W+VALUE_W-1:2*IDX_W];
    assign in_sx    = 64'(signed'(in_value));
    assign wr_data  = in_sx[ELEM_WIDTH-1:0];
    assign wr_addr  = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));

    assign wr_a_en = in_fire && (in_op == OP_WRITE_A)
                     && ({1'b0, in_row} < r_rows_a) && ({1'b0, in_col} < r_inner);
    assign wr_b_en = in_fire && (in_op == OP_WRITE_B)
                     && ({1'b0, in_row} < r_inner) && ({1'b0, in_col} < r_cols_b);

    // ---------------- issue sequencer ----------------
    logic [DIM_W-1:0]       r_ci, r_cj, r_ck;
    logic [FIFO_CNT_W-1:0]  r_resv;
    logic                   issue, k_last, j_last, i_last;
    logic                   pop;
    logic [ADDR_W-1:0]      rd_addr_a, rd_addr_b;

    assign k_last = (r_ck == r_inner - DIM_W'(1));
    assign j_last = (r_cj == r_cols_b - DIM_W'(1));
    assign i_last = (r_ci == r_rows_a - DIM_W'(1));
    // A new entry starts only when a queue slot is reserved for its result.
    assign issue  = r_busy && ((r_ck != '0) || (int'(r_resv) < FIFO_DEPTH));
    assign rd_addr_a = ADDR_W'(int'(r_ci) * MAX_DIM + int'(r_ck));
    assign rd_addr_b = ADDR_W'(int'(r_ck) * MAX_DIM + int'(r_cj));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ci   <= '0;
            r_cj   <= '0;
            r_ck   <= '0;
        end else if (!r_busy) begin
            if (in_fire && (in_op == OP_COMPUTE)) begin
                r_busy <= 1'b1;
                r_ci   <= '0;
                r_cj   <= '0;
                r_ck   <= '0;
            end
        end else if (issue) begin
            if (!k_last) begin
                r_ck <= r_ck + DIM_W'(1);
            end else begin
                r_ck <= '0;
                if (!j_last) begin
                    r_cj <= r_cj + DIM_W'(1);
                end else begin
                    r_cj <= '0;
                    if (i_last) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_ci <= r_ci + DIM_W'(1);
                    end
                end
            end
        end
    end

    logic reserve;
    assign reserve = issue && (r_ck == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resv <= '0;
        end else begin
            r_resv <= r_resv + FIFO_CNT_W'(reserve) - FIFO_CNT_W'(pop);
        end
    end

    // ---------------- element memories ----------------
    logic [ELEM_WIDTH-1:0] r_mem_a [DEPTH];
    logic [ELEM_WIDTH-1:0] r_mem_b [DEPTH];
    logic [ELEM_WIDTH-1:0] r_rd_a, r_rd_b;

    always_ff @(posedge i_clk) begin
        if (wr_a_en) begin
            r_mem_a[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem_a[rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b_en) begin
            r_mem_b[wr_addr] <= wr_data;
        end
        r_rd_b <= r_mem_b[rd_addr_b];
    end

    // ---------------- multiply-accumulate pipeline ----------------
    // Stage 1 tags travel alongside the memory read data.
    logic               r_s1_vld, r_s1_first, r_s1_klast, r_s1_last;
    logic [IDX_W-1:0]   r_s1_row, r_s1_col;
    logic               r_s2_vld, r_s2_first, r_s2_klast, r_s2_last;
    logic [IDX_W-1:0]   r_s2_row, r_s2_col;
    logic [VALUE_W-1:0] r_prod, r_acc, acc_sum;
    logic signed [63:0] a_sx, b_sx;
    logic [VALUE_W-1:0] a_lo, b_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= issue;
        end
        r_s1_first <= (r_ck == '0);
        r_s1_klast <= k_last;
        r_s1_last  <= k_last && j_last && i_last;
        r_s1_row   <= r_ci[IDX_W-1:0];
        r_s1_col   <= r_cj[IDX_W-1:0];
    end

    // Only the low 32 bits of each product reach the wrapped sum.
    assign a_sx = 64'(signed'(r_rd_a));
    assign b_sx = 64'(signed'(r_rd_b));
    assign a_lo = a_sx[VALUE_W-1:0];
    assign b_lo = b_sx[VALUE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_prod     <= a_lo * b_lo;
        r_s2_first <= r_s1_first;
        r_s2_klast <= r_s1_klast;
        r_s2_last  <= r_s1_last;
        r_s2_row   <= r_s1_row;
        r_s2_col   <= r_s1_col;
    end

    assign acc_sum = (r_s2_first ? '0 : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_acc <= acc_sum;
        end
    end

    // ---------------- result queue ----------------
    t_result                r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wptr, r_rptr;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic                   push;
    t_result                push_word, head;

    assign push = r_s2_vld && r_s2_klast;
    assign push_word = '{row: r_s2_row, col: r_s2_col, value: acc_sum, last: r_s2_last};
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + FIFO_PTR_W'(1);
            end
            r_count <= r_count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    assign head          = r_fifo[r_rptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {{(DATA_W - 2*IDX_W - VALUE_W){1'b0}},
                            head.value, head.col, head.row};

endmodule

`default_nettype wire
